@@ design/jse_pkg.sv @@
`timescale 1ns / 1ps
package jse_pkg;

	// output buffer size, the ellipsis is forced once the escaped text would pass BUF_BYTES - 4
	localparam int BUF_BYTES = 256;
	localparam int LIMIT     = BUF_BYTES - 4;
	localparam int LEN_W     = $clog2(LIMIT + 1);
	localparam int SUM_W     = $clog2(LIMIT + 7);

	// command queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CTRL_TOP  = 8'h20;

	typedef enum logic [2:0] {
		K_PLAIN,
		K_PAIR,
		K_UHEX,
		K_DOTS,
		K_TERM
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] val;
		logic       trunc;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = 8'h57 + {4'd0, nib};
		end
		return r;
	endfunction

	function automatic logic [2:0] cmd_len(input kind_t k);
		logic [2:0] r;
		case (k)
			K_PLAIN: r = 3'd1;
			K_PAIR:  r = 3'd2;
			K_UHEX:  r = 3'd6;
			K_DOTS:  r = 3'd3;
			K_TERM:  r = 3'd1;
			default: r = 3'd1;
		endcase
		return r;
	endfunction

endpackage

@@ design/json_string_escaper.sv @@
`timescale 1ns / 1ps
// json string escaper: takes a string one byte a beat on the slave side and
// sends its json-escaped form one byte a beat on the master side. quote and
// backslash become a backslash pair, backspace, form feed, newline, carriage
// return and tab their short forms, other bytes below 0x20 become \u00 and two
// lower-case hex digits, everything else passes unchanged. the block counts
// escaped bytes per string; when an escape would push that count past
// BUF_BYTES - 4 it sends "..." and drops the rest of the string. a beat with
// s_tlast high ends the string: data is ignored and a single nul byte goes out
// with m_tlast high and m_tuser set if the string was cut. the front end
// classifies one input beat per cycle into a command and the back end expands
// each command at one output byte per cycle, both unless stalled; a plain byte
// gives one, a short escape two, the ellipsis three, a \u00xx escape six; a
// four-entry command queue between them lets input flow while the output
// expands or stalls. output is registered. no clearing pass after reset.
module json_string_escaper import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // last
	output logic       m_tuser    // was_truncated
);

	// front to queue
	logic   push;
	cmd_t   push_cmd;
	// queue to back
	logic   pop;
	cmd_t   head;
	qstat_t qstat;

	// classify the beat, track escaped length and cut state
	jse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_end   (s_tlast),
		.qstat    (qstat),
		.in_ready (s_tready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// small command queue decoupling the two sides
	jse_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// expand each command into output bytes
	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast),
		.out_trunc (m_tuser)
	);

endmodule

@@ design/jse_front.sv @@
`timescale 1ns / 1ps
module jse_front import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  qstat_t     qstat,
	output logic       in_ready,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [LEN_W-1:0] out_length_q;
	logic             cut_q;
	logic             acc;
	logic [2:0]       need;
	logic [SUM_W-1:0] sum;
	logic             fits;
	kind_t            kind;
	logic [7:0]       sub;

	assign in_ready = !qstat.full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		kind = K_PLAIN;
		sub  = in_byte;
		case (in_byte)
			CH_QUOTE:  begin kind = K_PAIR; sub = CH_QUOTE;  end
			CH_BSLASH: begin kind = K_PAIR; sub = CH_BSLASH; end
			8'h08:     begin kind = K_PAIR; sub = 8'h62; end
			8'h0c:     begin kind = K_PAIR; sub = 8'h66; end
			8'h0a:     begin kind = K_PAIR; sub = 8'h6e; end
			8'h0d:     begin kind = K_PAIR; sub = 8'h72; end
			8'h09:     begin kind = K_PAIR; sub = 8'h74; end
			default: begin
				if (in_byte < CTRL_TOP) begin
					kind = K_UHEX;
				end
			end
		endcase
	end

	assign need = cmd_len(kind);
	assign sum  = SUM_W'(out_length_q) + SUM_W'(need);
	assign fits = (sum <= SUM_W'(LIMIT));

	always_comb begin
		push_cmd.kind  = kind;
		push_cmd.val   = sub;
		push_cmd.trunc = 1'b0;
		push           = acc;
		if (in_end) begin
			push_cmd.kind  = K_TERM;
			push_cmd.val   = CH_NUL;
			push_cmd.trunc = cut_q;
		end else if (cut_q) begin
			// rest of a cut string is dropped
			push = 1'b0;
		end else if (!fits) begin
			push_cmd.kind = K_DOTS;
			push_cmd.val  = CH_DOT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_length_q <= '0;
			cut_q        <= 1'b0;
		end else if (acc) begin
			if (in_end) begin
				out_length_q <= '0;
				cut_q        <= 1'b0;
			end else if (!cut_q) begin
				if (fits) begin
					out_length_q <= sum[LEN_W-1:0];
				end else begin
					cut_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ design/jse_queue.sv @@
`timescale 1ns / 1ps
module jse_queue import jse_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  cmd_t   push_cmd,
	input  logic   pop,
	output cmd_t   head,
	output qstat_t qstat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/jse_back.sv @@
`timescale 1ns / 1ps
module jse_back import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  qstat_t     qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_trunc
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       trunc_q;
	logic [2:0] idx_q;
	logic       load;
	logic       emit;
	logic       done;
	logic [7:0] nxt_byte;

	assign load = !valid_q || out_ready;
	assign emit = load && !qstat.empty;
	assign done = (idx_q == cmd_len(head.kind) - 3'd1);
	assign pop  = emit && done;

	always_comb begin
		nxt_byte = head.val;
		case (head.kind)
			K_PLAIN: nxt_byte = head.val;
			K_PAIR:  nxt_byte = (idx_q == 3'd0) ? CH_BSLASH : head.val;
			K_UHEX: begin
				case (idx_q)
					3'd0:    nxt_byte = CH_BSLASH;
					3'd1:    nxt_byte = CH_U;
					3'd2:    nxt_byte = CH_ZERO;
					3'd3:    nxt_byte = CH_ZERO;
					3'd4:    nxt_byte = hex_digit(head.val[7:4]);
					default: nxt_byte = hex_digit(head.val[3:0]);
				endcase
			end
			K_DOTS:  nxt_byte = CH_DOT;
			K_TERM:  nxt_byte = CH_NUL;
			default: nxt_byte = head.val;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= !qstat.empty;
			end
			if (emit) begin
				idx_q <= done ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= nxt_byte;
			last_q  <= (head.kind == K_TERM);
			trunc_q <= (head.kind == K_TERM) && head.trunc;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_trunc = trunc_q;

endmodule

@@ bench/jse_checker.sv @@
`timescale 1ns / 1ps
// watches both sides of the escaper, predicts the escaped byte stream and
// compares every output beat with the oldest predicted one
module jse_checker import jse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_string
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic       m_tlast,   // last
	input  logic       m_tuser,   // was_truncated
	output int         fail_count,
	output int         pending,
	output int         n_in,
	output int         n_out,
	output int         n_cut
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       trunc;
	} esc_beat_t;

	esc_beat_t        escaped_q[$];
	logic [LEN_W-1:0] emitted;
	logic             cut;
	esc_beat_t        want;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
	endfunction

	task automatic push_beat(input logic [7:0] ch, input logic l, input logic t);
		escaped_q.push_back('{ch: ch, last: l, trunc: t});
	endtask

	// one input beat in, its escaped bytes appended to the queue
	task automatic escape_byte(input logic [7:0] c, input logic eos);
		logic [7:0] sub;
		int         need;
		sub  = 8'h00;
		need = 1;
		if (eos) begin
			push_beat(CH_NUL, 1'b1, cut);
			emitted = '0;
			cut     = 1'b0;
		end else if (!cut) begin
			case (c)
				CH_QUOTE:  begin sub = CH_QUOTE;  need = 2; end
				CH_BSLASH: begin sub = CH_BSLASH; need = 2; end
				8'h08:     begin sub = "b"; need = 2; end
				8'h0c:     begin sub = "f"; need = 2; end
				8'h0a:     begin sub = "n"; need = 2; end
				8'h0d:     begin sub = "r"; need = 2; end
				8'h09:     begin sub = "t"; need = 2; end
				default: begin
					if (c < CTRL_TOP) need = 6;
				end
			endcase
			if (int'(emitted) + need > LIMIT) begin
				// escape does not fit, byte dropped and the string closed off
				cut = 1'b1;
				repeat (3) push_beat(CH_DOT, 1'b0, 1'b0);
			end else begin
				if (sub != 8'h00) begin
					push_beat(CH_BSLASH, 1'b0, 1'b0);
					push_beat(sub, 1'b0, 1'b0);
				end else if (c < CTRL_TOP) begin
					push_beat(CH_BSLASH, 1'b0, 1'b0);
					push_beat(CH_U, 1'b0, 1'b0);
					push_beat(CH_ZERO, 1'b0, 1'b0);
					push_beat(CH_ZERO, 1'b0, 1'b0);
					push_beat(hex_char(c[7:4]), 1'b0, 1'b0);
					push_beat(hex_char(c[3:0]), 1'b0, 1'b0);
				end else begin
					push_beat(c, 1'b0, 1'b0);
				end
				emitted = emitted + LEN_W'(need);
			end
		end
	endtask

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] exp);
		$display("tb: mismatch, %s: got %h, expected %h at %0t", what, got, exp, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escaped_q.delete();
			emitted    = '0;
			cut        = 1'b0;
			fail_count = 0;
			pending    = 0;
			n_in       = 0;
			n_out      = 0;
			n_cut      = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				escape_byte(s_tdata, s_tlast);
				n_in++;
			end
			if (m_tvalid && m_tready) begin
				n_out++;
				if (escaped_q.size() == 0) begin
					report("unexpected beat", m_tdata, 8'h00);
				end else begin
					want = escaped_q.pop_front();
					if (m_tdata !== want.ch) report("out_byte", m_tdata, want.ch);
					if (m_tlast !== want.last) report("last", 8'(m_tlast), 8'(want.last));
					if (m_tuser !== want.trunc) report("was_truncated", 8'(m_tuser), 8'(want.trunc));
					if (want.last && want.trunc) n_cut++;
				end
			end
			pending = escaped_q.size();
		end
	end

endmodule

@@ bench/json_string_escaper_tb.sv @@
`timescale 1ns / 1ps
// stimulus and verdict for the json string escaper; all prediction and
// comparison lives in jse_checker, which watches both channels
module json_string_escaper_tb;
	import jse_pkg::*;

	// receiver hold-off long enough to back up the command queue and the input
	localparam int HOLD_CYCLES    = 150;
	// no beat on either side for this long means the block has hung
	localparam int WATCHDOG_LIMIT = 2000;
	// drain time after the last expected beat, output is registered
	localparam int DRAIN_CYCLES   = 20;
	// input beats for the whole run, directed ones included
	localparam int TOTAL_ITEMS    = 130;

	typedef enum int {
		RX_OPEN,
		RX_HALF,
		RX_SPARSE
	} rx_mode_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;  // [7:0] data_byte
	logic       s_tlast  = 1'b0;   // end_of_string
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] out_byte
	logic       m_tlast;           // last
	logic       m_tuser;           // was_truncated

	int fail_count, pending, chk_in, chk_out, chk_cut;

	int n_sent     = 0;
	int n_strings  = 0;
	int burst_left = 0;
	int idle_count = 0;
	bit hold_req   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	json_string_escaper uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	jse_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.n_in       (chk_in),
		.n_out      (chk_out),
		.n_cut      (chk_cut)
	);

	// offer one beat and hold it until accepted; the sender runs in bursts of
	// random length and only drops tvalid in the gap between two bursts
	task automatic put_beat(input logic [7:0] d, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= eos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		n_sent++;
		if (eos) n_strings++;
	endtask

	// mostly text, with a good share of short escapes and control bytes
	function automatic logic [7:0] pick_byte();
		logic [7:0] shorts[7] = '{CH_QUOTE, CH_BSLASH, 8'h08, 8'h0c, 8'h0a, 8'h0d, 8'h09};
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1:    c = shorts[$urandom_range(0, 6)];
			2:       c = 8'($urandom_range(0, 31));
			default: c = 8'($urandom_range(0, 255));
		endcase
		return c;
	endfunction

	// a control byte that has no short form, so it costs six output bytes
	function automatic logic [7:0] pick_uhex();
		logic [7:0] c;
		bit         ok;
		ok = 1'b0;
		c  = 8'h00;
		while (!ok) begin
			c = 8'($urandom_range(0, 31));
			case (c)
				8'h08, 8'h09, 8'h0a, 8'h0c, 8'h0d: ok = 1'b0;
				default:                           ok = 1'b1;
			endcase
		end
		return c;
	endfunction

	// receiver: random ready pattern in modes of random length, plus one long
	// hold-off on request, counted here so the sender keeps pushing meanwhile
	initial begin : rx_side
		rx_mode_t mode;
		int       mode_left;
		int       held;
		mode      = RX_OPEN;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					RX_OPEN:   m_tready <= 1'b1;
					RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:   m_tready <= 1'b1;
				endcase
			end
		end
	end

	// watchdog: counts cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_count <= 0;
			end else begin
				idle_count <= idle_count + 1;
			end
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("tb: timeout, nothing moved for %0d cycles", WATCHDOG_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0] text[17] = '{8'h41, CH_QUOTE, CH_BSLASH, 8'h08, 8'h0c, 8'h0a, 8'h0d,
			8'h09, 8'h00, 8'h01, 8'h1f, 8'h0b, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'hff};
		int len;
		bit noisy;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string: terminator only, never truncated
		put_beat(8'h00, 1'b1);
		// every escape class plus the byte extremes; a zero data byte is \u0000
		foreach (text[i]) put_beat(text[i], 1'b0);
		// data on the end beat is ignored
		put_beat(8'hff, 1'b1);
		put_beat(CH_QUOTE, 1'b0);
		put_beat(CH_BSLASH, 1'b1);

		// long stall on the output while the sender keeps offering beats
		hold_req = 1'b1;

		// 42 six-byte escapes fill the buffer exactly, the next byte forces
		// the ellipsis and anything after it is dropped until the end beat
		repeat (42) put_beat(pick_uhex(), 1'b0);
		len = $urandom_range(1, 4);
		repeat (len) put_beat(pick_byte(), 1'b0);
		put_beat(8'($urandom_range(0, 255)), 1'b1);

		// heavy mixed string, the cut lands at a random point or not at all
		len = $urandom_range(40, 60);
		repeat (len) put_beat(($urandom_range(0, 1) == 1) ? pick_uhex() : pick_byte(), 1'b0);
		put_beat(8'($urandom_range(0, 255)), 1'b1);

		// short strings of random content, some of uniform noise
		while (n_sent < TOTAL_ITEMS) begin
			len   = $urandom_range(0, 10);
			noisy = ($urandom_range(0, 3) == 0);
			repeat (len) put_beat(noisy ? 8'($urandom_range(0, 255)) : pick_byte(), 1'b0);
			put_beat(8'($urandom_range(0, 255)), 1'b1);
		end
		s_tvalid <= 1'b0;

		wait (chk_in == n_sent && pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d input beats in %0d strings, %0d escaped beats out",
			n_sent, n_strings, chk_out);
		$display("tb: %0d strings closed with an ellipsis, %0d mismatches",
			chk_cut, fail_count);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ json_string_escaper.f @@
design/jse_pkg.sv
design/jse_front.sv
design/jse_queue.sv
design/jse_back.sv
design/json_string_escaper.sv
bench/jse_checker.sv
bench/json_string_escaper_tb.sv
